// ===== rtl/cc_pkg.sv =====
// shared types, constants and register map of the chacha20 stream cipher unit
package cc_pkg;

    localparam int CC_DOUBLE_ROUNDS = 10;
    localparam int CC_WORDS         = 16;
    localparam int CC_LANES         = 4;
    localparam int CC_CHUNKS        = 8;
    localparam int CC_ADDR_W        = 6;
    localparam int CC_DATA_W        = 64;

    localparam logic [31:0] CC_SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] CC_SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] CC_SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] CC_SIGMA_3 = 32'h6b20_6574;

    typedef enum logic [2:0] {
        REG_KEY_0_1   = 3'd0,
        REG_KEY_2_3   = 3'd1,
        REG_KEY_4_5   = 3'd2,
        REG_KEY_6_7   = 3'd3,
        REG_NONCE_0_1 = 3'd4,
        REG_NONCE_2   = 3'd5,
        REG_START_CNT = 3'd6
    } t_cc_reg;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_GEN  = 2'd1,
        ST_EMIT = 2'd2
    } t_cc_state;

    typedef struct packed {
        logic [63:0] data_chunk;
        logic        restart;
        logic        message_end;
    } t_cc_in;

    typedef struct packed {
        logic [63:0] cipher_chunk;
        logic [31:0] block_number;
        logic        block_last;
    } t_cc_out;

    typedef struct packed {
        logic [7:0][31:0] key;
        logic [2:0][31:0] nonce;
    } t_cc_cfg;

    typedef struct packed {
        logic        start;
        logic [31:0] counter;
    } t_cc_core_ctl;

endpackage

// ===== rtl/cc_qround.sv =====
// one chacha quarter round on four 32-bit words
module cc_qround
    import cc_pkg::*;
(
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    output logic [31:0] o_a,
    output logic [31:0] o_b,
    output logic [31:0] o_c,
    output logic [31:0] o_d
);

    logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;
    logic [31:0] dx1, bx1, dx2, bx2;

    always_comb begin
        a1  = i_a + i_b;
        dx1 = i_d ^ a1;
        d1  = {dx1[15:0], dx1[31:16]};
        c1  = i_c + d1;
        bx1 = i_b ^ c1;
        b1  = {bx1[19:0], bx1[31:20]};
        a2  = a1 + b1;
        dx2 = d1 ^ a2;
        d2  = {dx2[23:0], dx2[31:24]};
        c2  = c1 + d2;
        bx2 = b1 ^ c2;
        b2  = {bx2[24:0], bx2[31:25]};
        o_a = a2;
        o_b = b2;
        o_c = c2;
        o_d = d2;
    end

endmodule

// ===== rtl/cc_core.sv =====
// keystream block generator: four quarter-round lanes, one half round per cycle, feed-forward merge
module cc_core
    import cc_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = CC_DOUBLE_ROUNDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cc_core_ctl         i_ctl,
    input  t_cc_cfg              i_cfg,
    output logic                 o_done,
    output logic [7:0][63:0]     o_ks
);

    localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int HALF_W      = $clog2(HALF_ROUNDS);

    logic [31:0]        init_w [CC_WORDS];
    logic [31:0]        r_st   [CC_WORDS];
    logic [HALF_W-1:0]  r_half, n_half;
    logic               r_busy, n_busy;
    logic               r_ff, n_ff;
    logic               r_done;
    logic [7:0][63:0]   r_ks;
    logic               diag;

    logic [31:0] la [CC_LANES];
    logic [31:0] lb [CC_LANES];
    logic [31:0] lc [CC_LANES];
    logic [31:0] ld [CC_LANES];
    logic [31:0] qa [CC_LANES];
    logic [31:0] qb [CC_LANES];
    logic [31:0] qc [CC_LANES];
    logic [31:0] qd [CC_LANES];

    assign diag = r_half[0];

    always_comb begin
        init_w[0]  = CC_SIGMA_0;
        init_w[1]  = CC_SIGMA_1;
        init_w[2]  = CC_SIGMA_2;
        init_w[3]  = CC_SIGMA_3;
        for (int k = 0; k < 8; k++) begin
            init_w[4 + k] = i_cfg.key[k];
        end
        init_w[12] = i_ctl.counter;
        for (int k = 0; k < 3; k++) begin
            init_w[13 + k] = i_cfg.nonce[k];
        end
    end

    always_comb begin
        for (int i = 0; i < CC_LANES; i++) begin
            la[i] = r_st[i];
            if (diag) begin
                lb[i] = r_st[4 + ((i + 1) % 4)];
                lc[i] = r_st[8 + ((i + 2) % 4)];
                ld[i] = r_st[12 + ((i + 3) % 4)];
            end else begin
                lb[i] = r_st[4 + i];
                lc[i] = r_st[8 + i];
                ld[i] = r_st[12 + i];
            end
        end
    end

    for (genvar g = 0; g < CC_LANES; g++) begin : g_lane
        cc_qround u_qround (
            .i_a (la[g]),
            .i_b (lb[g]),
            .i_c (lc[g]),
            .i_d (ld[g]),
            .o_a (qa[g]),
            .o_b (qb[g]),
            .o_c (qc[g]),
            .o_d (qd[g])
        );
    end

    always_comb begin
        n_half = r_half;
        n_busy = r_busy;
        n_ff   = 1'b0;
        if (i_ctl.start) begin
            n_half = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_half = r_half + 1'b1;
            if (r_half == HALF_W'(HALF_ROUNDS - 1)) begin
                n_busy = 1'b0;
                n_ff   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= '0;
            r_busy <= 1'b0;
            r_ff   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_half <= n_half;
            r_busy <= n_busy;
            r_ff   <= n_ff;
            r_done <= r_ff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int k = 0; k < CC_WORDS; k++) begin
                r_st[k] <= init_w[k];
            end
        end else if (r_busy) begin
            for (int i = 0; i < CC_LANES; i++) begin
                r_st[i] <= qa[i];
                if (diag) begin
                    r_st[4 + ((i + 1) % 4)]  <= qb[i];
                    r_st[8 + ((i + 2) % 4)]  <= qc[i];
                    r_st[12 + ((i + 3) % 4)] <= qd[i];
                end else begin
                    r_st[4 + i]  <= qb[i];
                    r_st[8 + i]  <= qc[i];
                    r_st[12 + i] <= qd[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ff) begin
            for (int j = 0; j < CC_CHUNKS; j++) begin
                r_ks[j] <= {r_st[2 * j + 1] + init_w[2 * j + 1], r_st[2 * j] + init_w[2 * j]};
            end
        end
    end

    assign o_done = r_done;
    assign o_ks   = r_ks;

endmodule

// ===== rtl/chacha20_stream_cipher_unit.sv =====
// top level of the chacha20 stream cipher unit: register port, chunk control, output register
//
// items in: 64-bit data chunk with restart and message_end flags, valid/ready handshake
// items out: cipher chunk, block number and block_last flag, valid/ready handshake
// key, nonce and start counter are written over the apb port (64-bit data, 8-byte stride)
// while the unit is idle, a rule for the user that the unit does not enforce; pready is
// always high and reads return the register values; a chunk that needs a new keystream
// block (first chunk, restart, or after a block end) runs through the core, one half round per
// cycle on four quarter-round lanes, then the feed-forward merge, the hand-over state and
// the output register; the other chunks of a block (up to seven) go one per cycle straight
// to the output register while the receiver does not stall
// the output register takes a new item in the cycle the old one leaves; when the
// receiver stalls, ready drops and the waiting item holds on the output
// reset clears the apb registers, the block counter and the chunk position; the first chunk
// after reset always starts a fresh block
module chacha20_stream_cipher_unit
    import cc_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = CC_DOUBLE_ROUNDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [CC_ADDR_W-1:0] paddr,
    input  logic [CC_DATA_W-1:0] pwdata,
    output logic [CC_DATA_W-1:0] prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_cc_in               i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_cc_out              o_out_data
);

    logic [63:0] r_key01, r_key23, r_key45, r_key67, r_nonce01;
    logic [31:0] r_nonce2, r_start_cnt;

    t_cc_state   r_state, n_state;
    logic [31:0] r_counter, n_counter;
    logic [2:0]  r_pos, n_pos;
    logic        r_ks_ready, n_ks_ready;
    logic        r_out_valid, n_out_valid;
    t_cc_out     r_out, n_out;
    t_cc_in      r_hold, n_hold;

    t_cc_cfg       cfg;
    t_cc_core_ctl  core_ctl;
    logic          core_done;
    logic [7:0][63:0] core_ks;

    logic        wr_en;
    t_cc_reg     reg_sel;
    logic        out_free;
    logic        in_acc;
    logic        emit;
    logic        emit_last;
    t_cc_in      emit_item;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = t_cc_reg'(paddr[CC_ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key01     <= '0;
            r_key23     <= '0;
            r_key45     <= '0;
            r_key67     <= '0;
            r_nonce01   <= '0;
            r_nonce2    <= '0;
            r_start_cnt <= '0;
        end else if (wr_en) begin
            case (reg_sel)
                REG_KEY_0_1:   r_key01     <= pwdata;
                REG_KEY_2_3:   r_key23     <= pwdata;
                REG_KEY_4_5:   r_key45     <= pwdata;
                REG_KEY_6_7:   r_key67     <= pwdata;
                REG_NONCE_0_1: r_nonce01   <= pwdata;
                REG_NONCE_2:   r_nonce2    <= pwdata[31:0];
                REG_START_CNT: r_start_cnt <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_KEY_0_1:   prdata = r_key01;
            REG_KEY_2_3:   prdata = r_key23;
            REG_KEY_4_5:   prdata = r_key45;
            REG_KEY_6_7:   prdata = r_key67;
            REG_NONCE_0_1: prdata = r_nonce01;
            REG_NONCE_2:   prdata = {32'd0, r_nonce2};
            REG_START_CNT: prdata = {32'd0, r_start_cnt};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        cfg.key   = {r_key67[63:32], r_key67[31:0], r_key45[63:32], r_key45[31:0],
                     r_key23[63:32], r_key23[31:0], r_key01[63:32], r_key01[31:0]};
        cfg.nonce = {r_nonce2, r_nonce01[63:32], r_nonce01[31:0]};
    end

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;
    assign emit_item  = (r_state == ST_EMIT) ? r_hold : i_in_data;
    assign emit_last  = (r_pos == 3'd7) || emit_item.message_end;

    always_comb begin
        n_state          = r_state;
        n_counter        = r_counter;
        n_pos            = r_pos;
        n_ks_ready       = r_ks_ready;
        n_hold           = r_hold;
        n_out            = r_out;
        n_out_valid      = r_out_valid && !i_out_ready;
        core_ctl.start   = 1'b0;
        emit             = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.restart || !r_ks_ready) begin
                        if (i_in_data.restart) begin
                            n_counter = r_start_cnt;
                        end
                        n_pos          = '0;
                        n_ks_ready     = 1'b0;
                        n_hold         = i_in_data;
                        core_ctl.start = 1'b1;
                        n_state        = ST_GEN;
                    end else begin
                        emit = 1'b1;
                    end
                end
            end
            ST_GEN: begin
                if (core_done) begin
                    n_ks_ready = 1'b1;
                    n_state    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (emit) begin
            n_out.cipher_chunk = emit_item.data_chunk ^ core_ks[r_pos];
            n_out.block_number = r_counter;
            n_out.block_last   = emit_last;
            n_out_valid        = 1'b1;
            if (emit_last) begin
                n_ks_ready = 1'b0;
                n_pos      = '0;
                n_counter  = r_counter + 32'd1;
            end else begin
                n_pos = r_pos + 3'd1;
            end
        end

        core_ctl.counter = n_counter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_counter   <= '0;
            r_pos       <= '0;
            r_ks_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_counter   <= n_counter;
            r_pos       <= n_pos;
            r_ks_ready  <= n_ks_ready;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_hold <= n_hold;
    end

    cc_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_cfg   (cfg),
        .o_done  (core_done),
        .o_ks    (core_ks)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_gen_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN) |-> !r_ks_ready)
        else $error("keystream marked ready while a block is being generated");

    a_done_in_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_done |-> (r_state == ST_GEN))
        else $error("block done outside generation");

    a_emit_pos0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_pos == 3'd0) && r_ks_ready)
        else $error("fresh block not at chunk 0");

    a_last_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> !r_ks_ready && (r_pos == 3'd0))
        else $error("block not dropped after last chunk");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_ctl.start |=> (r_state == ST_GEN))
        else $error("block start without generation state");

endmodule

// ===== dv/chacha20_stream_cipher_unit_checker.sv =====
// checker for the chacha20 stream cipher unit: register tracking, keystream prediction, compare
module chacha20_stream_cipher_unit_checker
    import cc_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = CC_DOUBLE_ROUNDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [CC_ADDR_W-1:0] paddr,
    input  logic [CC_DATA_W-1:0] pwdata,
    input  logic                 pready,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  t_cc_in               i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  t_cc_out              i_out_data,
    output int                   o_mismatches,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] key_w   [8];
    logic [31:0] nonce_w [3];
    logic [31:0] start_ctr;
    logic [31:0] block_ctr;
    logic [31:0] ks_w    [16];
    logic [31:0] mix_w   [16];
    logic [2:0]  chunk_pos;
    logic        ks_valid;
    t_cc_out     cipher_q [$];
    int          mismatch_count = 0;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void quarter_round(input int a, input int b, input int c, input int d);
        mix_w[a] = mix_w[a] + mix_w[b];
        mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
        mix_w[c] = mix_w[c] + mix_w[d];
        mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
        mix_w[a] = mix_w[a] + mix_w[b];
        mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
        mix_w[c] = mix_w[c] + mix_w[d];
        mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
    endfunction

    function automatic void build_keystream();
        logic [31:0] init_w [16];
        init_w[0] = CC_SIGMA_0;
        init_w[1] = CC_SIGMA_1;
        init_w[2] = CC_SIGMA_2;
        init_w[3] = CC_SIGMA_3;
        for (int i = 0; i < 8; i++) init_w[4 + i] = key_w[i];
        init_w[12] = block_ctr;
        for (int i = 0; i < 3; i++) init_w[13 + i] = nonce_w[i];
        mix_w = init_w;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            quarter_round(0, 4, 8, 12);
            quarter_round(1, 5, 9, 13);
            quarter_round(2, 6, 10, 14);
            quarter_round(3, 7, 11, 15);
            quarter_round(0, 5, 10, 15);
            quarter_round(1, 6, 11, 12);
            quarter_round(2, 7, 8, 13);
            quarter_round(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) ks_w[i] = mix_w[i] + init_w[i];
    endfunction

    function automatic t_cc_out encrypt_chunk(input t_cc_in chunk);
        t_cc_out res;
        if (chunk.restart) begin
            block_ctr = start_ctr;
            ks_valid  = 1'b0;
        end
        if (!ks_valid) begin
            build_keystream();
            ks_valid  = 1'b1;
            chunk_pos = '0;
        end
        res.cipher_chunk = chunk.data_chunk ^ {ks_w[2 * chunk_pos + 1], ks_w[2 * chunk_pos]};
        res.block_number = block_ctr;
        res.block_last   = (chunk_pos == 3'(CC_CHUNKS - 1)) || chunk.message_end;
        if (res.block_last) begin
            ks_valid  = 1'b0;
            chunk_pos = '0;
            block_ctr = block_ctr + 32'd1;
        end else begin
            chunk_pos = chunk_pos + 3'd1;
        end
        return res;
    endfunction

    function automatic void apply_write(input logic [CC_ADDR_W-1:0] addr,
                                        input logic [CC_DATA_W-1:0] value);
        case (addr[CC_ADDR_W-1:3])
            REG_KEY_0_1:   {key_w[1], key_w[0]}     = value;
            REG_KEY_2_3:   {key_w[3], key_w[2]}     = value;
            REG_KEY_4_5:   {key_w[5], key_w[4]}     = value;
            REG_KEY_6_7:   {key_w[7], key_w[6]}     = value;
            REG_NONCE_0_1: {nonce_w[1], nonce_w[0]} = value;
            REG_NONCE_2:   nonce_w[2]               = value[31:0];
            REG_START_CNT: start_ctr                = value[31:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t checker: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_cc_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) key_w[i] = '0;
            for (int i = 0; i < 3; i++) nonce_w[i] = '0;
            for (int i = 0; i < 16; i++) ks_w[i] = '0;
            start_ctr = '0;
            block_ctr = '0;
            chunk_pos = '0;
            ks_valid  = 1'b0;
            cipher_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
            if (i_in_valid && i_in_ready) cipher_q.push_back(encrypt_chunk(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (cipher_q.size() == 0) begin
                    report_mismatch($sformatf("item %h with nothing expected", i_out_data));
                end else begin
                    want = cipher_q.pop_front();
                    if (i_out_data.cipher_chunk !== want.cipher_chunk)
                        report_mismatch($sformatf("cipher_chunk got %h expected %h",
                            i_out_data.cipher_chunk, want.cipher_chunk));
                    if (i_out_data.block_number !== want.block_number)
                        report_mismatch($sformatf("block_number got %h expected %h",
                            i_out_data.block_number, want.block_number));
                    if (i_out_data.block_last !== want.block_last)
                        report_mismatch($sformatf("block_last got %b expected %b",
                            i_out_data.block_last, want.block_last));
                end
            end
        end
        o_pending    <= cipher_q.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ===== dv/chacha20_stream_cipher_unit_tb.sv =====
// testbench top for the chacha20 stream cipher unit: clock, reset, stimulus and verdict
module chacha20_stream_cipher_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cc_pkg::*;

    localparam int          LATENCY      = 2 * CC_DOUBLE_ROUNDS + 3;
    localparam int          RANDOM_ITEMS = 1350;
    localparam int          PHASES       = 6;
    localparam int          MODE1_AT     = 460;
    localparam int          MODE2_AT     = 920;
    localparam int          HOLD_AT      = 1000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_LIMIT  = 5000;
    localparam logic [2:0]  REG_UNUSED   = 3'd7;

    typedef enum int {CFG_ZERO, CFG_ONES, CFG_WRAP, CFG_RANDOM} t_cfg_kind;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CC_ADDR_W-1:0] paddr;
    logic [CC_DATA_W-1:0] pwdata;
    logic [CC_DATA_W-1:0] prdata;
    logic                 pready;
    logic                 i_in_valid;
    logic                 o_in_ready;
    t_cc_in               i_in_data;
    logic                 o_out_valid;
    logic                 i_out_ready;
    t_cc_out              o_out_data;
    int                   mismatches;
    int                   pending;
    int                   sent_count = 0;

    always #6 i_clk = ~i_clk;

    chacha20_stream_cipher_unit #(.DOUBLE_ROUNDS(CC_DOUBLE_ROUNDS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    chacha20_stream_cipher_unit_checker #(.DOUBLE_ROUNDS(CC_DOUBLE_ROUNDS)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    function automatic int idle_pct(input bit rx);
        if (sent_count < MODE1_AT) begin
            return rx ? 74 : 10;
        end else if (sent_count < MODE2_AT) begin
            return rx ? 10 : 74;
        end
        return 0;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_chunk(input logic [63:0] data, input logic restart,
                              input logic msg_end);
        while ($urandom_range(99) < idle_pct(1'b0)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_chunk: data, restart: restart, message_end: msg_end};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
    endtask

    // mostly restart at the head and message end at the tail, noisy ones flag at random
    task automatic send_message(input int n_chunks, input bit noisy);
        logic restart;
        logic msg_end;
        for (int i = 0; i < n_chunks; i++) begin
            if (noisy) begin
                restart = ($urandom_range(3) == 0);
                msg_end = ($urandom_range(3) == 0);
            end else begin
                restart = (i == 0) ? ($urandom_range(9) < 7) : ($urandom_range(49) == 0);
                msg_end = (i == n_chunks - 1) ? ($urandom_range(9) < 7)
                                              : ($urandom_range(49) == 0);
            end
            send_chunk(rand64(), restart, msg_end);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CC_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CC_ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg_kind kind);
        logic [CC_DATA_W-1:0] value;
        for (int r = int'(REG_KEY_0_1); r <= int'(REG_START_CNT); r++) begin
            case (kind)
                CFG_ZERO: value = '0;
                CFG_ONES: value = '1;
                default:  value = rand64();
            endcase
            if (kind == CFG_WRAP && r == int'(REG_START_CNT))
                value[31:0] = 32'hffff_ffff - $urandom_range(3);
            write_reg(3'(r), value);
        end
        if (kind == CFG_ONES) write_reg(REG_UNUSED, '1);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    initial begin : receiver
        bit held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && sent_count >= HOLD_AT) begin
                held = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= ($urandom_range(99) >= idle_pct(1'b1));
            end
        end
    end

    initial begin : watchdog
        #6ms;
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        int phase_items;
        int n_chunks;
        int guard;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        i_rst_n    <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset values, first block from counter zero
        send_chunk('0, 1'b0, 1'b0);
        send_chunk('1, 1'b0, 1'b0);
        repeat (6) send_chunk(rand64(), 1'b0, 1'b0);
        send_chunk(rand64(), 1'b0, 1'b1);
        send_chunk(rand64(), 1'b0, 1'b0);
        send_chunk(rand64(), 1'b0, 1'b0);
        send_chunk(rand64(), 1'b1, 1'b0);
        send_chunk(rand64(), 1'b1, 1'b1);
        send_chunk('1, 1'b0, 1'b0);
        send_chunk('0, 1'b0, 1'b1);

        // all-ones key and nonce, counter wraps after one block
        wait_idle();
        program_regs(CFG_ONES);
        send_chunk('0, 1'b1, 1'b0);
        repeat (6) send_chunk(rand64(), 1'b0, 1'b0);
        send_chunk('1, 1'b0, 1'b0);
        send_chunk(rand64(), 1'b0, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            program_regs(t_cfg_kind'(ph % 4));
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / PHASES) begin
                n_chunks = $urandom_range(24, 1);
                send_message(n_chunks, $urandom_range(4) == 0);
                phase_items += n_chunks;
            end
        end
        i_in_valid <= 1'b0;

        for (guard = 0; guard < DRAIN_LIMIT && pending != 0; guard++) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
